// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tma_pkg.sv
// ----------------------------------------------------------------------------
// tma_pkg
// Types, field widths and fixed constants of the tilt moving average.
// ----------------------------------------------------------------------------
package tma_pkg;

    // Field widths
    localparam int ID_W     = 2;
    localparam int SAMPLE_W = 15;
    localparam int AVG_W    = 14;
    localparam int PCT_W    = 13;
    localparam int MAG_W    = 13;

    // Stream data widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 80;

    // Clamp limit: 90 degrees in 1/64 degree
    localparam logic [MAG_W-1:0] AVG_LIMIT = 13'd5760;

    // Largest percentage: 100 percent in 1/64 percent
    localparam logic [PCT_W-1:0] PCT_LIMIT = 13'd6400;

    // floor(m * 100 / 90) = m + floor(m / 9); m / 9 by reciprocal,
    // shift = MAG_W + ceil(log2 9), mult = ceil(2^17 / 9)
    localparam int                  PCT_SHIFT  = 17;
    localparam int                  PCT_MULT_W = 14;
    localparam logic [PCT_MULT_W-1:0] PCT_MULT = 14'd14564;
    localparam int                  PCT_PROD_W = MAG_W + PCT_MULT_W;
    localparam int                  NINTH_W    = PCT_PROD_W - PCT_SHIFT;

    typedef logic        [ID_W-1:0]     id_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [AVG_W-1:0]    avg_t;
    typedef logic        [PCT_W-1:0]    pct_t;

    // Pipeline stage enables
    typedef struct packed {
        logic load_s1;   // sample taken into stage 1
        logic move_s1;   // stage 1 -> stage 2 (window update)
        logic move_s2;   // stage 2 -> stage 3 (divide)
        logic move_s3;   // stage 3 -> output register
    } ctrl_t;

endpackage

// File: design/tilt_moving_average_split.sv
// An accepted sample's result reaches m_axis_tvalid through stage 1, stage 2, stage 3 and the output register.
// Throughput: one sample per cycle while m_axis_tready is high; stages are window update, divide, scale.
// Samples with a controller id at or above NUM_CONTROLLERS give no result.
// Reset clears window sums, slot pointers, wrap flags and stage valids; the
// history memory is not cleared, its entries read as zero until written.
// ----------------------------------------------------------------------------
// tilt_moving_average_split
// Boxcar average of roll and pitch per controller, clamped and split into
// one-sided percentages.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tilt_moving_average_split #(
    parameter int WINDOW_LEN      = 20,
    parameter int NUM_CONTROLLERS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // roll_sample[14:0], pitch_sample[29:15], zero [31:30]
    input  logic [tma_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // controller_id[1:0]
    input  logic [tma_pkg::ID_W-1:0]      s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // roll_avg[13:0], pitch_avg[27:14], roll_left[40:28], roll_right[53:41],
    // pitch_front[66:54], pitch_back[79:67]
    output logic [tma_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // controller_out[1:0]
    output logic [tma_pkg::ID_W-1:0]      m_axis_tuser
);

    localparam int CID_W  = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;
    localparam int SLOT_W = $clog2(WINDOW_LEN);
    localparam int SUM_W  = tma_pkg::SAMPLE_W + $clog2(WINDOW_LEN);

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_ok, s3_ok, s2_ok, s1_ok;
    logic in_fire, id_ok;
    tma_pkg::ctrl_t ctrl;

    tma_pkg::sample_t in_roll, in_pitch;
    tma_pkg::id_t     s2_id, s3_id_reg, out_id_reg;
    logic             s2_roll_neg, s2_pitch_neg;
    logic [SUM_W-1:0] s2_roll_mag, s2_pitch_mag;
    tma_pkg::avg_t    roll_avg, pitch_avg;
    tma_pkg::pct_t    roll_left, roll_right, pitch_front, pitch_back;

    // Ready chain: a stage may load when empty or when it empties this cycle
    assign out_ok = !out_valid_reg || m_axis_tready;
    assign s3_ok  = !s3_valid_reg || out_ok;
    assign s2_ok  = !s2_valid_reg || s3_ok;
    assign s1_ok  = !s1_valid_reg || s2_ok;

    assign s_axis_tready = s1_ok;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign id_ok         = {{(32 - tma_pkg::ID_W){1'b0}}, s_axis_tuser} < 32'(NUM_CONTROLLERS);

    assign ctrl.load_s1 = in_fire && id_ok;
    assign ctrl.move_s1 = s1_valid_reg && s2_ok;
    assign ctrl.move_s2 = s2_valid_reg && s3_ok;
    assign ctrl.move_s3 = s3_valid_reg && out_ok;

    // Stage valids
    always_comb
    begin
        s1_valid_next  = s1_ok  ? ctrl.load_s1 : s1_valid_reg;
        s2_valid_next  = s2_ok  ? s1_valid_reg : s2_valid_reg;
        s3_valid_next  = s3_ok  ? s2_valid_reg : s3_valid_reg;
        out_valid_next = out_ok ? s3_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Controller id follows the pipeline
    always_ff @(posedge clk)
    begin
        if (ctrl.move_s2)
        begin
            s3_id_reg <= s2_id;
        end
        if (ctrl.move_s3)
        begin
            out_id_reg <= s3_id_reg;
        end
    end

    assign in_roll  = tma_pkg::sample_t'(s_axis_tdata[tma_pkg::SAMPLE_W-1:0]);
    assign in_pitch = tma_pkg::sample_t'(s_axis_tdata[2*tma_pkg::SAMPLE_W-1:tma_pkg::SAMPLE_W]);

    tma_window #(
        .NUM_CONTROLLERS (NUM_CONTROLLERS),
        .WINDOW_LEN      (WINDOW_LEN),
        .CID_W           (CID_W),
        .SLOT_W          (SLOT_W),
        .SUM_W           (SUM_W)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .in_id        (s_axis_tuser),
        .in_roll      (in_roll),
        .in_pitch     (in_pitch),
        .s2_id        (s2_id),
        .s2_roll_neg  (s2_roll_neg),
        .s2_roll_mag  (s2_roll_mag),
        .s2_pitch_neg (s2_pitch_neg),
        .s2_pitch_mag (s2_pitch_mag)
    );

    // Negative roll is left, non-negative is right
    tma_axis_scale #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_roll_scale (
        .clk     (clk),
        .ctrl    (ctrl),
        .sum_neg (s2_roll_neg),
        .sum_mag (s2_roll_mag),
        .avg     (roll_avg),
        .pct_pos (roll_right),
        .pct_neg (roll_left)
    );

    // Non-negative pitch is front, negative is back
    tma_axis_scale #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_pitch_scale (
        .clk     (clk),
        .ctrl    (ctrl),
        .sum_neg (s2_pitch_neg),
        .sum_mag (s2_pitch_mag),
        .avg     (pitch_avg),
        .pct_pos (pitch_front),
        .pct_neg (pitch_back)
    );

    // Result transaction
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_id_reg;
    assign m_axis_tdata  = {pitch_back, pitch_front, roll_right, roll_left,
                            pitch_avg, roll_avg};

    // Assertions
    `ASSERT_IMPLIES(a_roll_one_side, m_axis_tvalid,
        (roll_left == '0) || (roll_right == '0), "roll split has both sides set")
    `ASSERT_IMPLIES(a_pitch_one_side, m_axis_tvalid,
        (pitch_front == '0) || (pitch_back == '0), "pitch split has both sides set")
    `ASSERT_IMPLIES(a_pct_bound, m_axis_tvalid,
        (roll_left <= tma_pkg::PCT_LIMIT) && (pitch_back <= tma_pkg::PCT_LIMIT),
        "percentage above limit")
    `ASSERT_IMPLIES(a_sink_frees_source, m_axis_tready, s_axis_tready,
        "input stalled while output ready")
    `ASSERT_NEXT(a_result_loaded, ctrl.move_s3, m_axis_tvalid,
        "result lost at output register")

endmodule

// File: design/tma_window.sv
// ----------------------------------------------------------------------------
// tma_window
// Per-controller sample history, slot pointers and running window sums.
// ----------------------------------------------------------------------------
module tma_window #(
    parameter int NUM_CONTROLLERS = 4,
    parameter int WINDOW_LEN      = 20,
    parameter int CID_W           = 2,
    parameter int SLOT_W          = 5,
    parameter int SUM_W           = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tma_pkg::ctrl_t    ctrl,
    input  tma_pkg::id_t      in_id,
    input  tma_pkg::sample_t  in_roll,
    input  tma_pkg::sample_t  in_pitch,
    output tma_pkg::id_t      s2_id,
    output logic              s2_roll_neg,
    output logic [SUM_W-1:0]  s2_roll_mag,
    output logic              s2_pitch_neg,
    output logic [SUM_W-1:0]  s2_pitch_mag
);

    localparam int ADDR_W  = CID_W + SLOT_W;
    localparam int DEPTH   = 2 ** ADDR_W;
    localparam int ENTRY_W = 2 * tma_pkg::SAMPLE_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);

    // Control state
    logic [SLOT_W-1:0]       slot_reg [NUM_CONTROLLERS];
    logic [NUM_CONTROLLERS-1:0] full_reg;
    logic signed [SUM_W-1:0] roll_sum_reg  [NUM_CONTROLLERS];
    logic signed [SUM_W-1:0] pitch_sum_reg [NUM_CONTROLLERS];

    // History memory, entry = {pitch, roll}
    logic [ENTRY_W-1:0] hist_mem [DEPTH];
    logic [ENTRY_W-1:0] hist_rd_reg;

    // Stage 1 payload
    tma_pkg::id_t      s1_id_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_old_ok_reg;
    tma_pkg::sample_t  s1_roll_reg;
    tma_pkg::sample_t  s1_pitch_reg;

    // Stage 2 payload
    tma_pkg::id_t      s2_id_reg;
    logic              s2_roll_neg_reg;
    logic [SUM_W-1:0]  s2_roll_mag_reg;
    logic              s2_pitch_neg_reg;
    logic [SUM_W-1:0]  s2_pitch_mag_reg;

    logic [CID_W-1:0]        in_idx;
    logic [SLOT_W-1:0]       in_slot;
    logic [SLOT_W-1:0]       slot_next;
    logic [CID_W-1:0]        s1_idx;
    tma_pkg::sample_t        old_roll;
    tma_pkg::sample_t        old_pitch;
    logic signed [SUM_W-1:0] roll_sum_next;
    logic signed [SUM_W-1:0] pitch_sum_next;
    logic                    roll_neg;
    logic                    pitch_neg;
    logic [SUM_W-1:0]        roll_mag;
    logic [SUM_W-1:0]        pitch_mag;

    // Slot lookup for the incoming sample
    assign in_idx    = CID_W'(in_id);
    assign in_slot   = slot_reg[in_idx];
    assign slot_next = (in_slot == SLOT_LAST) ? '0 : in_slot + SLOT_W'(1);

    // Oldest sample reads as zero until the window has wrapped once
    assign s1_idx    = CID_W'(s1_id_reg);
    assign old_roll  = s1_old_ok_reg ?
                       tma_pkg::sample_t'(hist_rd_reg[tma_pkg::SAMPLE_W-1:0]) : '0;
    assign old_pitch = s1_old_ok_reg ?
                       tma_pkg::sample_t'(hist_rd_reg[ENTRY_W-1:tma_pkg::SAMPLE_W]) : '0;

    // Running sum update, then sign and magnitude
    assign roll_sum_next  = roll_sum_reg[s1_idx] + SUM_W'(s1_roll_reg) - SUM_W'(old_roll);
    assign pitch_sum_next = pitch_sum_reg[s1_idx] + SUM_W'(s1_pitch_reg) - SUM_W'(old_pitch);
    assign roll_neg       = roll_sum_next[SUM_W-1];
    assign pitch_neg      = pitch_sum_next[SUM_W-1];
    assign roll_mag       = roll_neg ? SUM_W'(-roll_sum_next) : SUM_W'(roll_sum_next);
    assign pitch_mag      = pitch_neg ? SUM_W'(-pitch_sum_next) : SUM_W'(pitch_sum_next);

    // Slot pointers, wrap flags and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= '0;
            for (int i = 0; i < NUM_CONTROLLERS; i++)
            begin
                slot_reg[i]      <= '0;
                roll_sum_reg[i]  <= '0;
                pitch_sum_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctrl.load_s1)
            begin
                slot_reg[in_idx] <= slot_next;
                if (in_slot == SLOT_LAST)
                begin
                    full_reg[in_idx] <= 1'b1;
                end
            end
            if (ctrl.move_s1)
            begin
                roll_sum_reg[s1_idx]  <= roll_sum_next;
                pitch_sum_reg[s1_idx] <= pitch_sum_next;
            end
        end
    end

    // History memory: write on window update, registered read on accept
    always_ff @(posedge clk)
    begin
        if (ctrl.move_s1)
        begin
            hist_mem[s1_addr_reg] <= {s1_pitch_reg, s1_roll_reg};
        end
        if (ctrl.load_s1)
        begin
            hist_rd_reg <= hist_mem[{in_idx, in_slot}];
        end
    end

    // Stage 1 and stage 2 payload
    always_ff @(posedge clk)
    begin
        if (ctrl.load_s1)
        begin
            s1_id_reg     <= in_id;
            s1_addr_reg   <= {in_idx, in_slot};
            s1_old_ok_reg <= full_reg[in_idx];
            s1_roll_reg   <= in_roll;
            s1_pitch_reg  <= in_pitch;
        end
        if (ctrl.move_s1)
        begin
            s2_id_reg        <= s1_id_reg;
            s2_roll_neg_reg  <= roll_neg;
            s2_roll_mag_reg  <= roll_mag;
            s2_pitch_neg_reg <= pitch_neg;
            s2_pitch_mag_reg <= pitch_mag;
        end
    end

    assign s2_id        = s2_id_reg;
    assign s2_roll_neg  = s2_roll_neg_reg;
    assign s2_roll_mag  = s2_roll_mag_reg;
    assign s2_pitch_neg = s2_pitch_neg_reg;
    assign s2_pitch_mag = s2_pitch_mag_reg;

endmodule

// File: design/tma_axis_scale.sv
// ----------------------------------------------------------------------------
// tma_axis_scale
// One axis: window divide, clamp to +-90 degrees, one-sided percentages.
// ----------------------------------------------------------------------------
module tma_axis_scale #(
    parameter int WINDOW_LEN = 20,
    parameter int SUM_W      = 20
) (
    input  logic             clk,
    input  tma_pkg::ctrl_t   ctrl,
    input  logic             sum_neg,
    input  logic [SUM_W-1:0] sum_mag,
    output tma_pkg::avg_t    avg,
    output tma_pkg::pct_t    pct_pos,
    output tma_pkg::pct_t    pct_neg
);

    // Exact divide by WINDOW_LEN: mult = ceil(2^shift / len)
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_LEN);
    localparam int MULT_W    = SUM_W + 1;
    localparam int PROD_W    = SUM_W + MULT_W;
    localparam int Q_W       = PROD_W - DIV_SHIFT;
    localparam logic [63:0] DIV_ONE = 64'd1 << DIV_SHIFT;
    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'((DIV_ONE + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    logic [PROD_W-1:0]              div_prod;
    logic                           neg_reg;
    logic [Q_W-1:0]                 quot_reg;
    logic [tma_pkg::MAG_W-1:0]      mag;
    logic [tma_pkg::PCT_PROD_W-1:0] pct_prod;
    logic [tma_pkg::NINTH_W-1:0]    ninth;
    tma_pkg::pct_t                  pct;
    tma_pkg::avg_t                  avg_mag;
    tma_pkg::avg_t                  avg_reg;
    tma_pkg::pct_t                  pct_pos_reg;
    tma_pkg::pct_t                  pct_neg_reg;

    // Stage 3: quotient
    assign div_prod = PROD_W'(sum_mag) * PROD_W'(DIV_MULT);

    always_ff @(posedge clk)
    begin
        if (ctrl.move_s2)
        begin
            neg_reg  <= sum_neg;
            quot_reg <= div_prod[PROD_W-1:DIV_SHIFT];
        end
    end

    // Clamp and percentage: m * 10 / 9 = m + m / 9
    assign mag      = (quot_reg > Q_W'(tma_pkg::AVG_LIMIT)) ?
                      tma_pkg::AVG_LIMIT : quot_reg[tma_pkg::MAG_W-1:0];
    assign pct_prod = tma_pkg::PCT_PROD_W'(mag) * tma_pkg::PCT_PROD_W'(tma_pkg::PCT_MULT);
    assign ninth    = pct_prod[tma_pkg::PCT_PROD_W-1:tma_pkg::PCT_SHIFT];
    assign pct      = tma_pkg::PCT_W'(mag) + tma_pkg::PCT_W'(ninth);
    assign avg_mag  = tma_pkg::avg_t'(tma_pkg::AVG_W'(mag));

    // Output register
    always_ff @(posedge clk)
    begin
        if (ctrl.move_s3)
        begin
            avg_reg     <= neg_reg ? -avg_mag : avg_mag;
            pct_pos_reg <= neg_reg ? '0 : pct;
            pct_neg_reg <= neg_reg ? pct : '0;
        end
    end

    assign avg     = avg_reg;
    assign pct_pos = pct_pos_reg;
    assign pct_neg = pct_neg_reg;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for tilt_moving_average_split. Roll/pitch samples are
// streamed in for all four controllers. A bench-side window model predicts
// each result, and every output transaction is compared field by field
// against the oldest prediction. Directed extremes come first, then random
// bursts, a long output stall, and a final stretch without idle cycles.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WINDOW      = 20;
    localparam int CONTROLLERS = 4;
    localparam int MEAN_LIMIT  = 5760;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 10;
    localparam int MAX_REPORTS = 40;

    // Expected content of one output transaction
    typedef struct packed {
        tma_pkg::id_t  id;
        tma_pkg::avg_t roll_avg;
        tma_pkg::avg_t pitch_avg;
        tma_pkg::pct_t roll_left;
        tma_pkg::pct_t roll_right;
        tma_pkg::pct_t pitch_front;
        tma_pkg::pct_t pitch_back;
    } tilt_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [tma_pkg::S_DATA_W-1:0]  s_axis_tdata;
    logic [tma_pkg::ID_W-1:0]      s_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [tma_pkg::M_DATA_W-1:0]  m_axis_tdata;
    logic [tma_pkg::ID_W-1:0]      m_axis_tuser;

    // Bench copy of the window state
    int roll_hist  [CONTROLLERS][WINDOW];
    int pitch_hist [CONTROLLERS][WINDOW];
    int roll_sum   [CONTROLLERS];
    int pitch_sum  [CONTROLLERS];
    int next_slot  [CONTROLLERS];

    tilt_result_t pending_tilt[$];

    int  errors         = 0;
    int  samples_in     = 0;
    int  results_out    = 0;
    int  clamped_means  = 0;
    int  cycle_count    = 0;
    int  hold_request   = 0;
    bit  sender_idle    = 1'b1;
    bit  receiver_idle  = 1'b1;

    tilt_moving_average_split uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Truncated window mean, clamped to +-90 degrees
    function automatic int clamped_mean(input int sum);
        int q;
        q = sum / WINDOW;
        if (q > MEAN_LIMIT || q < -MEAN_LIMIT)
        begin
            clamped_means++;
            q = (q > 0) ? MEAN_LIMIT : -MEAN_LIMIT;
        end
        return q;
    endfunction

    // One-sided percentage in 1/64 percent
    function automatic tma_pkg::pct_t side_percent(input int mean);
        int mag;
        mag = (mean < 0) ? -mean : mean;
        return tma_pkg::pct_t'((mag * 100) / 90);
    endfunction

    // Push one sample into the window model and return the expected result
    function automatic tilt_result_t window_update(input tma_pkg::id_t id,
                                                   input tma_pkg::sample_t roll,
                                                   input tma_pkg::sample_t pitch);
        tilt_result_t res;
        int           slot;
        int           r_mean;
        int           p_mean;
        slot = next_slot[id];
        roll_sum[id]  += int'(roll) - roll_hist[id][slot];
        pitch_sum[id] += int'(pitch) - pitch_hist[id][slot];
        roll_hist[id][slot]  = int'(roll);
        pitch_hist[id][slot] = int'(pitch);
        next_slot[id] = (slot == WINDOW - 1) ? 0 : slot + 1;

        r_mean = clamped_mean(roll_sum[id]);
        p_mean = clamped_mean(pitch_sum[id]);
        res.id          = id;
        res.roll_avg    = tma_pkg::avg_t'(r_mean);
        res.pitch_avg   = tma_pkg::avg_t'(p_mean);
        res.roll_left   = (r_mean < 0)  ? side_percent(r_mean) : '0;
        res.roll_right  = (r_mean >= 0) ? side_percent(r_mean) : '0;
        res.pitch_front = (p_mean >= 0) ? side_percent(p_mean) : '0;
        res.pitch_back  = (p_mean < 0)  ? side_percent(p_mean) : '0;
        return res;
    endfunction

    task automatic report_field(input string name, input int expected, input int actual);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t ns: mismatch on %s, expected %0d, actual %0d",
                     $time, name, expected, actual);
    endtask

    // Scoreboard: check output transactions, then record accepted samples
    always @(posedge clk)
    begin
        tilt_result_t exp_res;
        tilt_result_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_out++;
                got.id          = m_axis_tuser;
                got.roll_avg    = m_axis_tdata[13:0];
                got.pitch_avg   = m_axis_tdata[27:14];
                got.roll_left   = m_axis_tdata[40:28];
                got.roll_right  = m_axis_tdata[53:41];
                got.pitch_front = m_axis_tdata[66:54];
                got.pitch_back  = m_axis_tdata[79:67];
                if (pending_tilt.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t ns: unexpected result, expected none, actual id %0d",
                                 $time, got.id);
                end
                else
                begin
                    exp_res = pending_tilt.pop_front();
                    if (got.id !== exp_res.id)
                        report_field("controller_out", exp_res.id, got.id);
                    if (got.roll_avg !== exp_res.roll_avg)
                        report_field("roll_avg", exp_res.roll_avg, got.roll_avg);
                    if (got.pitch_avg !== exp_res.pitch_avg)
                        report_field("pitch_avg", exp_res.pitch_avg, got.pitch_avg);
                    if (got.roll_left !== exp_res.roll_left)
                        report_field("roll_left", exp_res.roll_left, got.roll_left);
                    if (got.roll_right !== exp_res.roll_right)
                        report_field("roll_right", exp_res.roll_right, got.roll_right);
                    if (got.pitch_front !== exp_res.pitch_front)
                        report_field("pitch_front", exp_res.pitch_front, got.pitch_front);
                    if (got.pitch_back !== exp_res.pitch_back)
                        report_field("pitch_back", exp_res.pitch_back, got.pitch_back);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                samples_in++;
                pending_tilt.push_back(window_update(s_axis_tuser, s_axis_tdata[14:0],
                                                     s_axis_tdata[29:15]));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t ns: watchdog expired with %0d results outstanding",
                     $time, pending_tilt.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Output side: random stall bursts, plus a long hold-off on request
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else if (receiver_idle && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offer one sample and wait for its transaction; valid stays high on return
    task automatic send_sample(input tma_pkg::id_t id, input tma_pkg::sample_t roll,
                               input tma_pkg::sample_t pitch);
        if (sender_idle && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, pitch, roll};
        s_axis_tuser  <= id;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_tilt.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Sample generator for one burst style
    function automatic tma_pkg::sample_t pick_sample(input int mode, input int base);
        case (mode)
            0, 1, 2, 3: return tma_pkg::sample_t'(int'($urandom_range(0, 23040)) - 11520);
            4, 5:       return tma_pkg::sample_t'(base + int'($urandom_range(0, 128)) - 64);
            6:          return tma_pkg::sample_t'($urandom);
            7:
            begin
                case ($urandom_range(0, 6))
                    0: return tma_pkg::sample_t'(-16384);
                    1: return tma_pkg::sample_t'(16383);
                    2: return tma_pkg::sample_t'(-11520);
                    3: return tma_pkg::sample_t'(11520);
                    4: return tma_pkg::sample_t'(-1);
                    5: return tma_pkg::sample_t'(1);
                    default: return '0;
                endcase
            end
            8:          return tma_pkg::sample_t'(int'($urandom_range(0, 80)) - 40);
            default:    return tma_pkg::sample_t'(base);
        endcase
    endfunction

    function automatic int pick_base(input int mode);
        int mag;
        mag = (mode == 9) ? 16383 : int'($urandom_range(9000, 11450));
        return $urandom_range(0, 1) ? mag : -mag - ((mode == 9) ? 1 : 0);
    endfunction

    // Directed extremes
    task automatic test_directed_extremes();
        tma_pkg::sample_t big_neg;
        tma_pkg::sample_t big_pos;
        big_neg = tma_pkg::sample_t'(-16384);
        big_pos = tma_pkg::sample_t'(16383);
        // mean rounds to zero from either side
        send_sample(2'd0, 15'sd0, 15'sd0);
        send_sample(2'd0, 15'sd5, -15'sd19);
        // full-scale and nominal extremes
        send_sample(2'd1, big_pos, big_neg);
        send_sample(2'd1, -15'sd11520, 15'sd11520);
        send_sample(2'd2, 15'sd1, -15'sd1);
        send_sample(2'd2, 15'sd11520, -15'sd11520);
        // drive controller 3 hard into the clamp on both axes
        repeat (12) send_sample(2'd3, big_neg, big_pos);
        wait_for_drain();
    endtask

    // Random bursts: steady runs reach the clamp, the rest wander
    task automatic test_random_bursts(input int item_count);
        int            sent;
        int            len;
        int            mode;
        int            roll_base;
        int            pitch_base;
        tma_pkg::id_t  id;
        sent = 0;
        while (sent < item_count)
        begin
            id         = tma_pkg::id_t'($urandom_range(0, CONTROLLERS - 1));
            mode       = $urandom_range(0, 9);
            len        = (mode == 4 || mode == 5 || mode == 9) ? $urandom_range(15, 40)
                                                               : $urandom_range(1, 12);
            roll_base  = pick_base(mode);
            pitch_base = pick_base(mode);
            repeat (len)
            begin
                send_sample(id, pick_sample(mode, roll_base), pick_sample(mode, pitch_base));
                sent++;
                // occasionally interleave another controller
                if ($urandom_range(0, 7) == 0)
                    id = tma_pkg::id_t'($urandom_range(0, CONTROLLERS - 1));
            end
        end
        wait_for_drain();
    endtask

    // Long output stall while samples keep coming: input must back up
    task automatic test_backpressure();
        hold_request = 200;
        sender_idle  = 1'b0;
        repeat (60)
            send_sample(tma_pkg::id_t'($urandom_range(0, CONTROLLERS - 1)),
                        tma_pkg::sample_t'(int'($urandom_range(0, 23040)) - 11520),
                        tma_pkg::sample_t'(int'($urandom_range(0, 23040)) - 11520));
        sender_idle = 1'b1;
        wait_for_drain();
    endtask

    // Back-to-back traffic with no idle cycles on either side
    task automatic test_steady_stream();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        test_random_bursts(150);
    endtask

    initial
    begin
        for (int c = 0; c < CONTROLLERS; c++)
        begin
            roll_sum[c]  = 0;
            pitch_sum[c] = 0;
            next_slot[c] = 0;
            for (int s = 0; s < WINDOW; s++)
            begin
                roll_hist[c][s]  = 0;
                pitch_hist[c][s] = 0;
            end
        end
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_random_bursts(460);
        test_backpressure();
        test_steady_stream();

        $display("Covered %0d samples on %0d controllers, %0d results checked,",
                 samples_in, CONTROLLERS, results_out);
        $display("%0d clamped means, a 200-cycle output stall and a no-idle stretch.",
                 clamped_means);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
